// ===== hdl/dfc_pkg.sv =====
// ----------------------------------------------------------------------------
// dfc_pkg
// Shared types and constants of the lighting frame composer: word layouts,
// operation codes, register indexes and the control bundle of the compose
// stage.
// ----------------------------------------------------------------------------
`default_nettype none

package dfc_pkg;

  // fixed field widths
  localparam int MODE_W    = 3;
  localparam int CH_W      = 10;
  localparam int LEVEL_W   = 9;
  localparam int SLOT_W    = 8;
  localparam int COUNT_W   = 10;
  localparam int AGE_W     = 32;
  localparam int TIMEOUT_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  // default number of slots in a frame
  localparam int SLOT_COUNT_DEF = 512;

  // operation codes carried in the mode field
  localparam logic [MODE_W-1:0] MODE_SET_OVR = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_WRITE   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TICK    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ    = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIMEOUT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PIN     = 2'd2;

  // override entry meaning automatic (minus one)
  localparam logic [LEVEL_W-1:0] OVR_AUTO = 9'h1FF;

  // channel that the pin forces, and the value it forces
  localparam logic [CH_W-1:0]   PIN_CHANNEL = 10'd1;
  localparam logic [SLOT_W-1:0] PIN_LEVEL   = 8'h01;

  // input word
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [CH_W-1:0]    channel;
    logic [LEVEL_W-1:0] level;
    logic               frame_end;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [SLOT_W-1:0]  slot_level;
    logic               override_any;
    logic [COUNT_W-1:0] override_total;
    logic               blacked_out;
  } out_word_t;

  // state and settings the compose stage looks at
  typedef struct packed {
    logic                 fire;
    logic [CH_W-1:0]      channel;
    logic                 in_range;
    logic                 manual_enable;
    logic                 first_pin;
    logic [TIMEOUT_W-1:0] hold_timeout;
    logic                 frame_seen;
    logic [AGE_W-1:0]     frame_age;
    logic [CH_W-1:0]      frame_length;
    logic [COUNT_W-1:0]   override_count;
  } comp_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/dfc_ram.sv =====
// ----------------------------------------------------------------------------
// dfc_ram
// Simple dual-port synchronous memory: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dfc_ram #(
  parameter int DEPTH = dfc_pkg::SLOT_COUNT_DEF,
  parameter int WIDTH = dfc_pkg::SLOT_W
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/dfc_compose.sv =====
// ----------------------------------------------------------------------------
// dfc_compose
// Builds one output slot from the stored slot byte and override entry:
// blackout, override overlay, zero padding, start code and channel-one pin,
// then registers the result word and its strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module dfc_compose (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire dfc_pkg::comp_ctl_t             ctl,
  input  wire logic [dfc_pkg::SLOT_W-1:0]     slot_rdata,
  input  wire logic [dfc_pkg::LEVEL_W-1:0]    ovr_rdata,
  output logic                                out_valid,
  output dfc_pkg::out_word_t                  out_data
);

  logic                       blackout;
  logic                       overlay;
  logic [dfc_pkg::SLOT_W-1:0] level;
  logic                       out_valid_r;
  dfc_pkg::out_word_t         out_data_r;

  // hold timeout and overlay conditions
  assign blackout = (ctl.hold_timeout != '0) && ctl.frame_seen &&
                    (ctl.frame_age > {{(dfc_pkg::AGE_W - dfc_pkg::TIMEOUT_W){1'b0}},
                                      ctl.hold_timeout});
  assign overlay  = ctl.manual_enable && (ctl.override_count != '0);

  // slot value
  always_comb begin
    level = blackout ? '0 : slot_rdata;
    if (overlay && !ovr_rdata[dfc_pkg::LEVEL_W-1]) begin
      level = ovr_rdata[dfc_pkg::SLOT_W-1:0];
    end
    // padding past the frame length only without overlay
    if (!overlay && (ctl.channel > ctl.frame_length)) begin
      level = '0;
    end
    if (!ctl.in_range) begin
      level = '0;
    end
    if (ctl.first_pin && (ctl.channel == dfc_pkg::PIN_CHANNEL)) begin
      level = dfc_pkg::PIN_LEVEL;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.fire;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (ctl.fire) begin
      out_data_r.slot_level     <= level;
      out_data_r.override_any   <= (ctl.override_count != '0);
      out_data_r.override_total <= ctl.override_count;
      out_data_r.blacked_out    <= blackout;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== hdl/dmx_frame_composer_core.sv =====
// ----------------------------------------------------------------------------
// dmx_frame_composer_core
// Lighting frame composer: received slot memory, manual override memory and
// the control that reads, updates and composes them.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. Slot writes and ticks
// leave busy low, so the block stays ready for the next word. Reads and
// override sets go on to the READ or SETOV state with busy high, because both
// go through the registered read data of the slot and override memories
// before composing or updating the override count. A read's result word
// shows on out_data with out_valid high for exactly one cycle, registered in
// the compose stage from the READ state; the receiver cannot stall it and
// must take it then. After reset the block runs a clearing pass over both
// memories, and after a clear-overrides word over the override memory only,
// one entry a cycle with busy high; configuration writes are taken at any
// time.
// ----------------------------------------------------------------------------
`default_nettype none

module dmx_frame_composer_core #(
  parameter int SLOT_COUNT = dfc_pkg::SLOT_COUNT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire dfc_pkg::in_word_t                 in_data,
  output logic                                   out_valid,
  output dfc_pkg::out_word_t                     out_data,
  input  wire logic                              cfg_we,
  input  wire logic [dfc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dfc_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int AW = $clog2(SLOT_COUNT);
  localparam logic [dfc_pkg::CH_W-1:0] SLOT_MAX  = dfc_pkg::CH_W'(SLOT_COUNT);
  localparam logic [AW-1:0]            SWEEP_END = AW'(SLOT_COUNT - 1);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SETOV = 4'b0100,
    ST_READ  = 4'b1000
  } state_t;

  state_t                            state_r, state_nxt;
  logic [AW-1:0]                     sweep_r, sweep_nxt;
  logic                              clr_slots_r, clr_slots_nxt;
  logic [AW-1:0]                     op_addr_r;
  logic [dfc_pkg::LEVEL_W-1:0]       op_level_r;
  logic [dfc_pkg::CH_W-1:0]          op_ch_r;
  logic                              op_in_range_r;
  logic [dfc_pkg::COUNT_W-1:0]       ovr_count_r, ovr_count_nxt;
  logic [dfc_pkg::CH_W-1:0]          frame_len_r, frame_len_nxt;
  logic [dfc_pkg::AGE_W-1:0]         age_r, age_nxt;
  logic                              seen_r, seen_nxt;
  logic                              man_en_r;
  logic [dfc_pkg::TIMEOUT_W-1:0]     timeout_r;
  logic                              pin_r;

  logic                              accept;
  logic                              in_range;
  logic                              level_ok;
  logic [AW-1:0]                     in_addr;
  logic                              was_ovr, now_ovr;

  logic                              slot_we;
  logic [AW-1:0]                     slot_waddr;
  logic [dfc_pkg::SLOT_W-1:0]        slot_wdata;
  logic [dfc_pkg::SLOT_W-1:0]        slot_rdata;
  logic                              ovr_we;
  logic [AW-1:0]                     ovr_waddr;
  logic [dfc_pkg::LEVEL_W-1:0]       ovr_wdata;
  logic [dfc_pkg::LEVEL_W-1:0]       ovr_rdata;
  dfc_pkg::comp_ctl_t                comp_ctl;

  // handshake and decode
  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign in_range = (in_data.channel != '0) && (in_data.channel <= SLOT_MAX);
  assign level_ok = !in_data.level[dfc_pkg::LEVEL_W-1] || (in_data.level == dfc_pkg::OVR_AUTO);
  assign in_addr  = in_data.channel[AW-1:0] - AW'(1);
  assign was_ovr  = !ovr_rdata[dfc_pkg::LEVEL_W-1];
  assign now_ovr  = !op_level_r[dfc_pkg::LEVEL_W-1];

  // sequencer and scalar state
  always_comb begin
    state_nxt     = state_r;
    sweep_nxt     = sweep_r;
    clr_slots_nxt = clr_slots_r;
    ovr_count_nxt = ovr_count_r;
    frame_len_nxt = frame_len_r;
    age_nxt       = age_r;
    seen_nxt      = seen_r;
    case (state_r)
      ST_CLEAR: begin
        sweep_nxt = sweep_r + AW'(1);
        if (sweep_r == SWEEP_END) begin
          state_nxt     = ST_IDLE;
          sweep_nxt     = '0;
          clr_slots_nxt = 1'b0;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_data.mode)
            dfc_pkg::MODE_SET_OVR: begin
              if (in_range && level_ok) begin
                state_nxt = ST_SETOV;
              end
            end
            dfc_pkg::MODE_CLEAR: begin
              state_nxt     = ST_CLEAR;
              sweep_nxt     = '0;
              ovr_count_nxt = '0;
            end
            dfc_pkg::MODE_WRITE: begin
              if (in_data.frame_end) begin
                frame_len_nxt = (in_data.channel > SLOT_MAX) ? SLOT_MAX : in_data.channel;
                age_nxt       = '0;
                seen_nxt      = 1'b1;
              end
            end
            dfc_pkg::MODE_TICK: begin
              if (age_r != '1) begin
                age_nxt = age_r + dfc_pkg::AGE_W'(1);
              end
            end
            dfc_pkg::MODE_READ: begin
              state_nxt = ST_READ;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SETOV: begin
        // count follows the change of the entry's active state
        if (now_ovr && !was_ovr) begin
          ovr_count_nxt = ovr_count_r + dfc_pkg::COUNT_W'(1);
        end else if (!now_ovr && was_ovr && (ovr_count_r != '0)) begin
          ovr_count_nxt = ovr_count_r - dfc_pkg::COUNT_W'(1);
        end
        state_nxt = ST_IDLE;
      end
      ST_READ: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      sweep_r     <= '0;
      clr_slots_r <= 1'b1;
      ovr_count_r <= '0;
      frame_len_r <= '0;
      age_r       <= '0;
      seen_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      clr_slots_r <= clr_slots_nxt;
      ovr_count_r <= ovr_count_nxt;
      frame_len_r <= frame_len_nxt;
      age_r       <= age_nxt;
      seen_r      <= seen_nxt;
    end
  end

  // operand hold for the read or set state
  always_ff @(posedge clk) begin
    if (accept) begin
      op_addr_r     <= in_addr;
      op_level_r    <= in_data.level;
      op_ch_r       <= in_data.channel;
      op_in_range_r <= in_range;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      man_en_r  <= 1'b0;
      timeout_r <= '0;
      pin_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        dfc_pkg::CFG_MANUAL_ENABLE: man_en_r  <= cfg_wdata[0];
        dfc_pkg::CFG_HOLD_TIMEOUT:  timeout_r <= cfg_wdata[dfc_pkg::TIMEOUT_W-1:0];
        dfc_pkg::CFG_FIRST_PIN:     pin_r     <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // slot memory write port: clearing pass or received slot
  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = in_addr;
    slot_wdata = in_data.level[dfc_pkg::SLOT_W-1:0];
    if (state_r == ST_CLEAR) begin
      slot_we    = clr_slots_r;
      slot_waddr = sweep_r;
      slot_wdata = '0;
    end else if (accept && (in_data.mode == dfc_pkg::MODE_WRITE) && in_range) begin
      slot_we = 1'b1;
    end
  end

  // override memory write port: clearing pass or write-back of a set
  always_comb begin
    ovr_we    = 1'b0;
    ovr_waddr = op_addr_r;
    ovr_wdata = op_level_r;
    if (state_r == ST_CLEAR) begin
      ovr_we    = 1'b1;
      ovr_waddr = sweep_r;
      ovr_wdata = dfc_pkg::OVR_AUTO;
    end else if (state_r == ST_SETOV) begin
      ovr_we = 1'b1;
    end
  end

  dfc_ram #(
    .DEPTH (SLOT_COUNT),
    .WIDTH (dfc_pkg::SLOT_W)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (in_addr),
    .rdata (slot_rdata)
  );

  dfc_ram #(
    .DEPTH (SLOT_COUNT),
    .WIDTH (dfc_pkg::LEVEL_W)
  ) u_ovr_ram (
    .clk   (clk),
    .we    (ovr_we),
    .waddr (ovr_waddr),
    .wdata (ovr_wdata),
    .raddr (in_addr),
    .rdata (ovr_rdata)
  );

  // compose stage control bundle
  always_comb begin
    comp_ctl.fire           = (state_r == ST_READ);
    comp_ctl.channel        = op_ch_r;
    comp_ctl.in_range       = op_in_range_r;
    comp_ctl.manual_enable  = man_en_r;
    comp_ctl.first_pin      = pin_r;
    comp_ctl.hold_timeout   = timeout_r;
    comp_ctl.frame_seen     = seen_r;
    comp_ctl.frame_age      = age_r;
    comp_ctl.frame_length   = frame_len_r;
    comp_ctl.override_count = ovr_count_r;
  end

  dfc_compose u_compose (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (comp_ctl),
    .slot_rdata (slot_rdata),
    .ovr_rdata  (ovr_rdata),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

  // a result word only follows a read cycle
  a_out_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_READ))
    else $error("result word without a read cycle");

  // a read cycle always yields a result word
  a_read_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |=> out_valid)
    else $error("read cycle lost its result word");

  // override count stays within the slot count
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ovr_count_r <= SLOT_MAX)
    else $error("override count beyond slot count");

  // a set cycle is only entered from an accepted in-range set word
  a_setov_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SETOV) |-> $past(accept && (in_data.mode == dfc_pkg::MODE_SET_OVR)
                                     && in_range))
    else $error("override set cycle without a valid set word");

  // frame length never passes the slot count
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    frame_len_r <= SLOT_MAX)
    else $error("frame length beyond slot count");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the lighting frame composer. A driver feeds command
// words from a queue, a monitor predicts every read result from a bench-side
// copy of the slot store, override table, frame length and frame age, and
// checks each result word field by field. The run walks several register
// settings, a short directed list, then random frames, reads, overrides and
// ticks under different sender idle rates.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = dfc_pkg::SLOT_COUNT_DEF;

  // command word waiting to be driven, optionally held until all reads drain
  typedef struct {
    dfc_pkg::in_word_t word;
    bit                drain;
  } pending_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  dfc_pkg::in_word_t             in_data = '0;
  logic                          out_valid;
  dfc_pkg::out_word_t            out_data;
  logic                          cfg_we = 1'b0;
  logic [dfc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [dfc_pkg::CFG_W-1:0]     cfg_wdata = '0;

  dmx_frame_composer_core #(.SLOT_COUNT(SLOTS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // bench copy of the composer state and settings
  logic [dfc_pkg::SLOT_W-1:0]         slot_mem [1:SLOTS];
  logic signed [dfc_pkg::LEVEL_W-1:0] ovr_mem  [1:SLOTS];
  int                                 ovr_count;
  int                                 frame_len;
  logic [dfc_pkg::AGE_W-1:0]          frame_age;
  logic                               frame_seen;
  logic                               man_en;
  logic [dfc_pkg::TIMEOUT_W-1:0]      hold_ms;
  logic                               pin_on;

  pending_t           pending_words[$];
  dfc_pkg::out_word_t composed_words[$];
  int                 words_sent = 0;
  int                 words_taken = 0;
  int                 queued_items = 0;
  int                 idle_pct = 0;
  int                 frame_hint = 0;
  int                 errors = 0;

  task automatic clear_state();
    for (int i = 1; i <= SLOTS; i++) begin
      slot_mem[i] = '0;
      ovr_mem[i] = -1;
    end
    ovr_count = 0;
    frame_len = 0;
    frame_age = '0;
    frame_seen = 1'b0;
    man_en = 1'b0;
    hold_ms = '0;
    pin_on = 1'b0;
  endtask

  function automatic logic hold_expired();
    return hold_ms != 0 && frame_seen && frame_age > hold_ms;
  endfunction

  // blackout, then override overlay, then padding, then start code and pin
  function automatic logic [dfc_pkg::SLOT_W-1:0] compose_slot(int ch);
    logic                       overlay;
    int                         span;
    logic [dfc_pkg::SLOT_W-1:0] v;
    overlay = man_en && ovr_count != 0;
    span = overlay ? SLOTS : frame_len;
    if (ch == 0 || ch > SLOTS) return '0;
    v = hold_expired() ? '0 : slot_mem[ch];
    if (overlay && ovr_mem[ch] >= 0) v = ovr_mem[ch][dfc_pkg::SLOT_W-1:0];
    if (ch > span) v = '0;
    if (ch == dfc_pkg::PIN_CHANNEL && pin_on) v = dfc_pkg::PIN_LEVEL;
    return v;
  endfunction

  // update the bench state for one taken word, queue a result for reads
  task automatic absorb_word(dfc_pkg::in_word_t w);
    logic signed [dfc_pkg::LEVEL_W-1:0] lv;
    int                                 ch;
    logic                               was_on;
    logic                               now_on;
    dfc_pkg::out_word_t                 r;
    lv = w.level;
    ch = w.channel;
    case (w.mode)
      dfc_pkg::MODE_SET_OVR: begin
        if (ch >= 1 && ch <= SLOTS && lv >= -1) begin
          was_on = ovr_mem[ch] >= 0;
          now_on = lv >= 0;
          ovr_mem[ch] = lv;
          if (now_on && !was_on) ovr_count++;
          else if (was_on && !now_on && ovr_count != 0) ovr_count--;
        end
      end
      dfc_pkg::MODE_CLEAR: begin
        for (int i = 1; i <= SLOTS; i++) ovr_mem[i] = -1;
        ovr_count = 0;
      end
      dfc_pkg::MODE_WRITE: begin
        if (ch >= 1 && ch <= SLOTS) slot_mem[ch] = w.level[dfc_pkg::SLOT_W-1:0];
        if (w.frame_end) begin
          frame_len = ch > SLOTS ? SLOTS : ch;
          frame_age = '0;
          frame_seen = 1'b1;
        end
      end
      dfc_pkg::MODE_TICK: begin
        if (frame_age != '1) frame_age++;
      end
      dfc_pkg::MODE_READ: begin
        r.slot_level = compose_slot(ch);
        r.override_any = ovr_count != 0;
        r.override_total = ovr_count[dfc_pkg::COUNT_W-1:0];
        r.blacked_out = hold_expired();
        composed_words.push_back(r);
      end
      default: ;
    endcase
  endtask

  // driver: a word stays on the bus until taken, then the next one or a gap
  always @(negedge clk) begin
    pending_t p;
    logic     load;
    if (rst_n && !(start && words_taken != words_sent)) begin
      load = pending_words.size() != 0 && $urandom_range(0, 99) >= idle_pct;
      if (load && pending_words[0].drain && composed_words.size() != 0) load = 1'b0;
      if (load) begin
        p = pending_words.pop_front();
        in_data <= p.word;
        start <= 1'b1;
        words_sent++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check result words, then predict for a word taken at this edge
  always @(posedge clk) begin
    dfc_pkg::out_word_t want;
    if (rst_n && out_valid) begin
      if (composed_words.size() == 0) begin
        $error("result word with nothing expected: %h", out_data);
        errors++;
      end else begin
        want = composed_words.pop_front();
        if (out_data.slot_level !== want.slot_level) begin
          $error("slot_level: expected %0h, got %0h", want.slot_level, out_data.slot_level);
          errors++;
        end
        if (out_data.override_any !== want.override_any) begin
          $error("override_any: expected %0d, got %0d", want.override_any,
                 out_data.override_any);
          errors++;
        end
        if (out_data.override_total !== want.override_total) begin
          $error("override_total: expected %0d, got %0d", want.override_total,
                 out_data.override_total);
          errors++;
        end
        if (out_data.blacked_out !== want.blacked_out) begin
          $error("blacked_out: expected %0d, got %0d", want.blacked_out,
                 out_data.blacked_out);
          errors++;
        end
      end
    end
    if (rst_n && start && !busy) begin
      absorb_word(in_data);
      words_taken++;
    end
  end

  task automatic add_word(logic [dfc_pkg::MODE_W-1:0] mode, int ch, int lvl, logic fe,
                          bit drain);
    pending_t p;
    p.word.mode = mode;
    p.word.channel = ch[dfc_pkg::CH_W-1:0];
    p.word.level = lvl[dfc_pkg::LEVEL_W-1:0];
    p.word.frame_end = fe;
    p.drain = drain;
    pending_words.push_back(p);
    queued_items++;
  endtask

  // wait until every word is taken, every read answered and the block is quiet
  task automatic settle();
    while (pending_words.size() != 0 || start || composed_words.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
    while (busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [dfc_pkg::CFG_IDX_W-1:0] idx,
                           logic [dfc_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      dfc_pkg::CFG_MANUAL_ENABLE: man_en = val[0];
      dfc_pkg::CFG_HOLD_TIMEOUT:  hold_ms = val;
      dfc_pkg::CFG_FIRST_PIN:     pin_on = val[0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic man, logic [dfc_pkg::TIMEOUT_W-1:0] hold, logic pin);
    write_reg(dfc_pkg::CFG_MANUAL_ENABLE, dfc_pkg::CFG_W'(man));
    write_reg(dfc_pkg::CFG_HOLD_TIMEOUT, hold);
    write_reg(dfc_pkg::CFG_FIRST_PIN, dfc_pkg::CFG_W'(pin));
  endtask

  // mostly near the current frame, sometimes the edges or anywhere
  function automatic int pick_channel();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, frame_hint + 4);
    if (r < 85) begin
      case ($urandom_range(0, 3))
        0: return 0;
        1: return 1;
        2: return SLOTS;
        default: return SLOTS + 1;
      endcase
    end
    return $urandom_range(0, 1023);
  endfunction

  task automatic random_words(int quota);
    int goal;
    int r;
    int n;
    int len;
    int top;
    int lvl;
    goal = queued_items + quota;
    while (queued_items < goal) begin
      r = $urandom_range(0, 99);
      if (r < 28) begin
        // received frame: a few slots, then the closing slot
        r = $urandom_range(0, 99);
        if (r < 70) len = $urandom_range(1, 40);
        else if (r < 94) len = $urandom_range(1, SLOTS);
        else if (r < 97) len = 0;
        else len = $urandom_range(SLOTS + 1, 1023);
        top = (len == 0 || len > SLOTS) ? SLOTS : len;
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++)
          add_word(dfc_pkg::MODE_WRITE, $urandom_range(1, top), $urandom_range(0, 511),
                   1'b0, 1'b0);
        add_word(dfc_pkg::MODE_WRITE, len, $urandom_range(0, 511), 1'b1, 1'b0);
        frame_hint = len > SLOTS ? SLOTS : len;
      end else if (r < 55) begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
          add_word(dfc_pkg::MODE_READ, pick_channel(), $urandom_range(0, 511),
                   1'($urandom_range(0, 1)), $urandom_range(0, 99) < 3);
      end else if (r < 70) begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
          r = $urandom_range(0, 99);
          if (r < 40) lvl = -1;
          else if (r < 90) lvl = $urandom_range(0, 255);
          else lvl = $urandom_range(0, 511);
          add_word(dfc_pkg::MODE_SET_OVR, pick_channel(), lvl, 1'($urandom_range(0, 1)),
                   1'b0);
        end
      end else if (r < 82) begin
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5);
        for (int i = 0; i < n; i++)
          add_word(dfc_pkg::MODE_TICK, $urandom_range(0, 1023), $urandom_range(0, 511),
                   1'($urandom_range(0, 1)), 1'b0);
      end else if (r < 84) begin
        add_word(dfc_pkg::MODE_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 511),
                 1'($urandom_range(0, 1)), 1'b0);
      end else if (r < 92) begin
        // stray slot writes anywhere, frame end at random
        add_word(dfc_pkg::MODE_WRITE, $urandom_range(0, 1023), $urandom_range(0, 511),
                 1'($urandom_range(0, 1)), 1'b0);
      end else begin
        // unused operation codes
        add_word(dfc_pkg::MODE_W'($urandom_range(5, 7)), $urandom_range(0, 1023),
                 $urandom_range(0, 511), 1'($urandom_range(0, 1)), 1'b0);
      end
    end
  endtask

  task automatic run_phase(int pct, logic man, logic [dfc_pkg::TIMEOUT_W-1:0] hold,
                           logic pin, int quota);
    settle();
    set_regs(man, hold, pin);
    idle_pct = pct;
    random_words(quota);
  endtask

  initial begin
    clear_state();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed words
    set_regs(1'b1, 16'd1, 1'b0);
    idle_pct = 6;
    add_word(dfc_pkg::MODE_READ, 1, 0, 1'b0, 1'b0);
    add_word(dfc_pkg::MODE_WRITE, 1, 'hAB, 1'b0, 1'b0);
    // negative byte keeps its low eight bits
    add_word(dfc_pkg::MODE_WRITE, 2, -1, 1'b0, 1'b0);
    add_word(dfc_pkg::MODE_WRITE, SLOTS, 255, 1'b0, 1'b0);
    add_word(dfc_pkg::MODE_WRITE, 3, 'h12, 1'b1, 1'b0);
    add_word(dfc_pkg::MODE_READ, 2, 0, 1'b0, 1'b0);
    // past the frame length, start code, far out of range
    add_word(dfc_pkg::MODE_READ, SLOTS, 0, 1'b0, 1'b0);
    add_word(dfc_pkg::MODE_READ, 0, 0, 1'b0, 1'b0);
    add_word(dfc_pkg::MODE_READ, 1023, 0, 1'b0, 1'b0);
    add_word(dfc_pkg::MODE_SET_OVR, SLOTS, 'h80, 1'b0, 1'b0);
    // overrides ignored: start code, beyond the last slot, level below minus one
    add_word(dfc_pkg::MODE_SET_OVR, 0, 5, 1'b0, 1'b0);
    add_word(dfc_pkg::MODE_SET_OVR, 600, 5, 1'b0, 1'b0);
    add_word(dfc_pkg::MODE_SET_OVR, 4, -2, 1'b0, 1'b0);
    // overlay lifts the padding
    add_word(dfc_pkg::MODE_READ, SLOTS, 0, 1'b0, 1'b0);
    add_word(dfc_pkg::MODE_TICK, 0, 0, 1'b0, 1'b0);
    add_word(dfc_pkg::MODE_TICK, 0, 0, 1'b0, 1'b0);
    // blackout, with the override still showing
    add_word(dfc_pkg::MODE_READ, 1, 0, 1'b0, 1'b0);
    add_word(dfc_pkg::MODE_READ, SLOTS, 0, 1'b0, 1'b0);
    add_word(dfc_pkg::MODE_SET_OVR, SLOTS, -1, 1'b0, 1'b0);
    add_word(dfc_pkg::MODE_CLEAR, 0, 0, 1'b0, 1'b0);
    // frame end on the start code, then beyond the last slot
    add_word(dfc_pkg::MODE_WRITE, 0, 7, 1'b1, 1'b0);
    add_word(dfc_pkg::MODE_WRITE, 700, 9, 1'b1, 1'b0);
    add_word(3'd5, 1, 1, 1'b1, 1'b0);
    add_word(3'd7, 1023, 511, 1'b1, 1'b0);
    add_word(dfc_pkg::MODE_READ, 2, 0, 1'b0, 1'b1);

    // random phases over several settings and idle rates
    run_phase(6, 1'b1, 16'd0, 1'b1, 300);
    run_phase(86, 1'b0, 16'hFFFF, 1'b0, 300);
    run_phase(0, 1'b1, 16'd12, 1'b0, 300);
    run_phase(0, 1'b1, dfc_pkg::TIMEOUT_W'($urandom_range(1, 40)), 1'b1, 300);
    settle();

    if (errors == 0 && composed_words.size() == 0) begin
      $display("[dmx_frame_composer_core] OK");
    end else begin
      $display("[dmx_frame_composer_core] ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #3_000_000;
    $display("[dmx_frame_composer_core] ERROR");
    $finish;
  end

endmodule
